[design/preemptive_priority_task_scheduler_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define PPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PPTS_ASSERT(lbl, prop, msg)
`define PPTS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[design/pts_pkg.sv]
// Types, codes and default sizes of the task scheduler.
`default_nettype none
package pts_pkg;
  localparam int NUM_TASKS_DEF        = 8;
  localparam int ACTIONS_PER_TASK_DEF = 8;
  localparam int TIME_BITS_DEF        = 16;

  localparam logic [1:0] ACT_LOAD_TASK   = 2'd0;
  localparam logic [1:0] ACT_LOAD_ACTION = 2'd1;
  localparam logic [1:0] ACT_TICK        = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [2:0] ST_NOT_ARRIVED = 3'd0;
  localparam logic [2:0] ST_READY       = 3'd1;
  localparam logic [2:0] ST_RUN         = 3'd2;
  localparam logic [2:0] ST_WAIT        = 3'd3;
  localparam logic [2:0] ST_FINISH      = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  task_index;
    logic [15:0] arrive_time;
    logic [7:0]  task_priority;
    logic [2:0]  action_slot;
    logic [15:0] action_time;
    logic [1:0]  action_kind;
    logic [15:0] action_data;
  } pts_in_t;

  typedef struct packed {
    logic        running_valid;
    logic [2:0]  running_task;
    logic        finished_valid;
    logic [2:0]  finished_task;
    logic [15:0] finish_turnover;
    logic [15:0] finish_run_time;
    logic [15:0] finish_start_time;
  } pts_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } pts_qcmd_t;
endpackage
`default_nettype wire

[design/pts_ram.sv]
// Single-port-write, registered-read memory.
`default_nettype none
module pts_ram import pts_pkg::*; #(
  parameter int W  = 8,
  parameter int AW = 3
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output      logic [W-1:0]  rdata
);
  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/pts_queue.sv]
// First-in first-out task queue held as a shift line.
`default_nettype none
module pts_queue import pts_pkg::*; #(
  parameter int DEPTH = NUM_TASKS_DEF,
  parameter int EW    = 3,
  parameter int CW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pts_qcmd_t     cmd,
  input  wire logic [EW-1:0] push_data,
  output      logic [EW-1:0] head,
  output      logic [CW-1:0] count
);
  logic [EW-1:0] q_r   [DEPTH];
  logic [EW-1:0] q_nxt [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt, tail;

  always_comb begin
    tail = cnt_r;
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (cmd.pop && cnt_r != '0) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      tail = cnt_r - 1'b1;
    end
    cnt_nxt = tail;
    if (cmd.push && tail < CW'(DEPTH)) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tail == CW'(i)) begin
          q_nxt[i] = push_data;
        end
      end
      cnt_nxt = tail + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign head  = q_r[0];
  assign count = cnt_r;
endmodule
`default_nettype wire

[design/preemptive_priority_task_scheduler.sv]
// Top level of the preemptive priority task scheduler.
//
// An input word is accepted at a clock edge with start high and busy low. Load-task
// words set a slot's arrival tick and priority, load-action words set one timed action,
// and tick words advance the schedule by one clock tick. Every word produces exactly one
// result word on out_data, marked by out_valid for a single cycle; the receiver cannot
// stall it. The result shows the running task after the word and any task that finished.
// A load word is decoded and, for a load-task word, its task record is then written. A tick
// walks the task records, the wait and ready queues and, when a task runs, its action
// entries; it is paced by the read-modify-write loop on the task record memory, which
// reads and then writes each entry in turn.
// After reset a clearing pass writes every task record and every action entry, one per
// cycle; busy stays high meanwhile.
`default_nettype none
`include "preemptive_priority_task_scheduler_macros.svh"
module preemptive_priority_task_scheduler import pts_pkg::*; #(
  parameter int NUM_TASKS        = NUM_TASKS_DEF,
  parameter int ACTIONS_PER_TASK = ACTIONS_PER_TASK_DEF,
  parameter int TIME_BITS        = TIME_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output      logic    busy,
  input  wire pts_in_t in_data,
  output      logic    out_valid,
  output      pts_out_t out_data
);
  localparam int TW     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SW     = (ACTIONS_PER_TASK > 1) ? $clog2(ACTIONS_PER_TASK) : 1;
  localparam int CW     = $clog2(NUM_TASKS + 1);
  localparam int KW     = $clog2(ACTIONS_PER_TASK + 1);
  localparam int CLR_AW = TW + SW;

  typedef struct packed {
    logic [2:0]           status;
    logic [TIME_BITS-1:0] arrival;
    logic [7:0]           prio;
    logic [TIME_BITS-1:0] run_time;
    logic [TIME_BITS-1:0] wait_left;
    logic [TIME_BITS-1:0] start_time;
    logic                 start_set;
  } rec_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] atime;
    logic [1:0]           kind;
    logic [TIME_BITS-1:0] data;
  } act_t;

  typedef enum logic [21:0] {
    S_CLEAR    = 22'b1 << 0,
    S_IDLE     = 22'b1 << 1,
    S_DECODE   = 22'b1 << 2,
    S_LD_WR    = 22'b1 << 3,
    S_ARR_RD   = 22'b1 << 4,
    S_ARR_WR   = 22'b1 << 5,
    S_WQ_RD    = 22'b1 << 6,
    S_WQ_WR    = 22'b1 << 7,
    S_UPD_RD   = 22'b1 << 8,
    S_UPD_WR   = 22'b1 << 9,
    S_REC_RD   = 22'b1 << 10,
    S_REC_LD   = 22'b1 << 11,
    S_ACT_RD   = 22'b1 << 12,
    S_ACT_CHK  = 22'b1 << 13,
    S_PICK_SET = 22'b1 << 14,
    S_PICK_RD  = 22'b1 << 15,
    S_PICK_CHK = 22'b1 << 16,
    S_REM      = 22'b1 << 17,
    S_OLD_WR   = 22'b1 << 18,
    S_NEW_RD   = 22'b1 << 19,
    S_DONE     = 22'b1 << 20,
    S_NEW_WR   = 22'b1 << 21
  } state_t;

  state_t               state_r, state_nxt;
  pts_in_t              in_r, in_nxt;
  logic [TIME_BITS-1:0] cur_time_r, cur_time_nxt;
  logic [CW-1:0]        idx_r, idx_nxt, lim_r, lim_nxt, pick_pos_r, pick_pos_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [TW-1:0]        run_slot_r, run_slot_nxt, pick_task_r, pick_task_nxt;
  logic                 run_active_r, run_active_nxt;
  rec_t                 rrec_r, rrec_nxt;
  logic                 have_best_r, have_best_nxt, found_r, found_nxt;
  logic [7:0]           best_prio_r, best_prio_nxt;
  logic                 fin_valid_r, fin_valid_nxt;
  logic [TW-1:0]        fin_task_r, fin_task_nxt;
  logic [TIME_BITS-1:0] fin_turn_r, fin_turn_nxt, fin_run_r, fin_run_nxt;
  logic [TIME_BITS-1:0] fin_start_r, fin_start_nxt;
  logic [CLR_AW-1:0]    clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pts_out_t             out_data_r, out_data_nxt;

  logic                 rec_we;
  logic [TW-1:0]        rec_waddr, rec_raddr;
  rec_t                 rec_wdata, rec_rd;
  logic [$bits(rec_t)-1:0] rec_rdata;
  logic                 act_we;
  logic [CLR_AW-1:0]    act_waddr, act_raddr;
  act_t                 act_wdata, act_rd;
  logic [$bits(act_t)-1:0] act_rdata;

  pts_qcmd_t            rq_cmd, wq_cmd;
  logic [TW-1:0]        rq_push_data, wq_push_data, rq_head, wq_head;
  logic [CW-1:0]        rq_count, wq_count;
  logic                 ti_ok, slot_ok;

  pts_ram #(.W($bits(rec_t)), .AW(TW)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  pts_ram #(.W($bits(act_t)), .AW(CLR_AW)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  pts_queue #(.DEPTH(NUM_TASKS), .EW(TW), .CW(CW)) u_ready_q (
    .clk(clk), .rst_n(rst_n), .cmd(rq_cmd), .push_data(rq_push_data),
    .head(rq_head), .count(rq_count)
  );

  pts_queue #(.DEPTH(NUM_TASKS), .EW(TW), .CW(CW)) u_wait_q (
    .clk(clk), .rst_n(rst_n), .cmd(wq_cmd), .push_data(wq_push_data),
    .head(wq_head), .count(wq_count)
  );

  assign rec_rd  = rec_t'(rec_rdata);
  assign act_rd  = act_t'(act_rdata);
  assign ti_ok   = int'(in_r.task_index) < NUM_TASKS;
  assign slot_ok = int'(in_r.action_slot) < ACTIONS_PER_TASK;

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    cur_time_nxt   = cur_time_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    pick_pos_nxt   = pick_pos_r;
    k_nxt          = k_r;
    run_slot_nxt   = run_slot_r;
    pick_task_nxt  = pick_task_r;
    run_active_nxt = run_active_r;
    rrec_nxt       = rrec_r;
    have_best_nxt  = have_best_r;
    found_nxt      = found_r;
    best_prio_nxt  = best_prio_r;
    fin_valid_nxt  = fin_valid_r;
    fin_task_nxt   = fin_task_r;
    fin_turn_nxt   = fin_turn_r;
    fin_run_nxt    = fin_run_r;
    fin_start_nxt  = fin_start_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    rec_we         = 1'b0;
    rec_waddr      = '0;
    rec_wdata      = rec_rd;
    rec_raddr      = '0;
    act_we         = 1'b0;
    act_waddr      = '0;
    act_wdata      = '0;
    act_raddr      = {run_slot_r, k_r[SW-1:0]};
    rq_cmd         = '0;
    wq_cmd         = '0;
    rq_push_data   = '0;
    wq_push_data   = '0;

    case (state_r)
      S_CLEAR: begin
        rec_we         = 1'b1;
        rec_waddr      = clr_r[TW-1:0];
        rec_wdata      = '0;
        act_we         = 1'b1;
        act_waddr      = clr_r;
        act_wdata.kind = KIND_NONE;
        clr_nxt        = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt        = in_data;
          fin_valid_nxt = 1'b0;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        rec_raddr = TW'(in_r.task_index);
        case (in_r.action)
          ACT_LOAD_TASK: begin
            if (ti_ok) begin
              state_nxt = S_LD_WR;
            end
          end
          ACT_LOAD_ACTION: begin
            if (ti_ok && slot_ok) begin
              act_we          = 1'b1;
              act_waddr       = {TW'(in_r.task_index), SW'(in_r.action_slot)};
              act_wdata.atime = TIME_BITS'(in_r.action_time);
              act_wdata.kind  = in_r.action_kind;
              act_wdata.data  = TIME_BITS'(in_r.action_data);
            end
          end
          ACT_TICK: begin
            idx_nxt   = '0;
            state_nxt = S_ARR_RD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_LD_WR: begin
        rec_we            = 1'b1;
        rec_waddr         = TW'(in_r.task_index);
        rec_wdata.arrival = TIME_BITS'(in_r.arrive_time);
        rec_wdata.prio    = in_r.task_priority;
        state_nxt         = S_DONE;
      end
      S_ARR_RD: begin
        rec_raddr = idx_r[TW-1:0];
        state_nxt = S_ARR_WR;
      end
      S_ARR_WR: begin
        if (rec_rd.status == ST_NOT_ARRIVED && rec_rd.arrival == cur_time_r) begin
          rec_we           = 1'b1;
          rec_waddr        = idx_r[TW-1:0];
          rec_wdata.status = ST_READY;
          rq_cmd.push      = 1'b1;
          rq_push_data     = idx_r[TW-1:0];
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_ARR_RD;
        if (idx_r == CW'(NUM_TASKS - 1)) begin
          idx_nxt   = '0;
          lim_nxt   = wq_count;
          state_nxt = S_WQ_RD;
        end
      end
      S_WQ_RD: begin
        rec_raddr = wq_head;
        state_nxt = S_WQ_WR;
        if (idx_r == lim_r) begin
          idx_nxt   = '0;
          state_nxt = S_UPD_RD;
        end
      end
      S_WQ_WR: begin
        wq_cmd.pop = 1'b1;
        if (rec_rd.wait_left == '0) begin
          rec_we           = 1'b1;
          rec_waddr        = wq_head;
          rec_wdata.status = ST_READY;
          rq_cmd.push      = 1'b1;
          rq_push_data     = wq_head;
        end else begin
          wq_cmd.push  = 1'b1;
          wq_push_data = wq_head;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_WQ_RD;
      end
      S_UPD_RD: begin
        rec_raddr = idx_r[TW-1:0];
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        rec_we    = 1'b1;
        rec_waddr = idx_r[TW-1:0];
        if (rec_rd.status == ST_RUN) begin
          rec_wdata.run_time = rec_rd.run_time + 1'b1;
        end else if (rec_rd.status == ST_WAIT && rec_rd.wait_left != '0) begin
          rec_wdata.wait_left = rec_rd.wait_left - 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_UPD_RD;
        if (idx_r == CW'(NUM_TASKS - 1)) begin
          state_nxt = run_active_r ? S_REC_RD : S_PICK_SET;
        end
      end
      S_REC_RD: begin
        rec_raddr = run_slot_r;
        state_nxt = S_REC_LD;
      end
      S_REC_LD: begin
        rrec_nxt  = rec_rd;
        k_nxt     = '0;
        state_nxt = S_ACT_RD;
      end
      S_ACT_RD: begin
        state_nxt = S_ACT_CHK;
      end
      S_ACT_CHK: begin
        if ((act_rd.kind == KIND_BLOCK || act_rd.kind == KIND_FINISH) &&
            act_rd.atime == rrec_r.run_time) begin
          rec_we         = 1'b1;
          rec_waddr      = run_slot_r;
          rec_wdata      = rrec_r;
          run_active_nxt = 1'b0;
          if (act_rd.kind == KIND_BLOCK) begin
            rec_wdata.status    = ST_WAIT;
            rec_wdata.wait_left = act_rd.data;
            wq_cmd.push         = 1'b1;
            wq_push_data        = run_slot_r;
          end else begin
            rec_wdata.status = ST_FINISH;
            fin_valid_nxt    = 1'b1;
            fin_task_nxt     = run_slot_r;
            fin_turn_nxt     = cur_time_r - rrec_r.arrival;
            fin_run_nxt      = rrec_r.run_time;
            fin_start_nxt    = rrec_r.start_time;
          end
          state_nxt = S_PICK_SET;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_ACT_RD;
          if (k_r == KW'(ACTIONS_PER_TASK - 1)) begin
            state_nxt = S_PICK_SET;
          end
        end
      end
      S_PICK_SET: begin
        idx_nxt       = '0;
        lim_nxt       = rq_count;
        have_best_nxt = run_active_r;
        best_prio_nxt = rrec_r.prio;
        found_nxt     = 1'b0;
        state_nxt     = S_PICK_RD;
      end
      S_PICK_RD: begin
        rec_raddr = rq_head;
        state_nxt = S_PICK_CHK;
        if (idx_r == lim_r) begin
          idx_nxt   = '0;
          state_nxt = found_r ? S_REM : S_DONE;
        end
      end
      S_PICK_CHK: begin
        if (!have_best_r || rec_rd.prio > best_prio_r) begin
          have_best_nxt = 1'b1;
          best_prio_nxt = rec_rd.prio;
          found_nxt     = 1'b1;
          pick_pos_nxt  = idx_r;
          pick_task_nxt = rq_head;
        end
        rq_cmd.pop   = 1'b1;
        rq_cmd.push  = 1'b1;
        rq_push_data = rq_head;
        idx_nxt      = idx_r + 1'b1;
        state_nxt    = S_PICK_RD;
      end
      S_REM: begin
        if (idx_r == lim_r) begin
          state_nxt = run_active_r ? S_OLD_WR : S_NEW_RD;
        end else begin
          rq_cmd.pop   = 1'b1;
          rq_cmd.push  = (idx_r != pick_pos_r);
          rq_push_data = rq_head;
          idx_nxt      = idx_r + 1'b1;
        end
      end
      S_OLD_WR: begin
        rec_we           = 1'b1;
        rec_waddr        = run_slot_r;
        rec_wdata        = rrec_r;
        rec_wdata.status = ST_READY;
        rq_cmd.push      = 1'b1;
        rq_push_data     = run_slot_r;
        state_nxt        = S_NEW_RD;
      end
      S_NEW_RD: begin
        rec_raddr = pick_task_r;
        state_nxt = S_NEW_WR;
      end
      S_NEW_WR: begin
        rec_we           = 1'b1;
        rec_waddr        = pick_task_r;
        rec_wdata.status = ST_RUN;
        if (!rec_rd.start_set) begin
          rec_wdata.start_set  = 1'b1;
          rec_wdata.start_time = cur_time_r;
        end
        run_slot_nxt   = pick_task_r;
        run_active_nxt = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (in_r.action == ACT_TICK) begin
          cur_time_nxt = cur_time_r + 1'b1;
        end
        out_valid_nxt                  = 1'b1;
        out_data_nxt.running_valid     = run_active_r;
        out_data_nxt.running_task      = run_active_r ? 3'(run_slot_r) : 3'd0;
        out_data_nxt.finished_valid    = fin_valid_r;
        out_data_nxt.finished_task     = fin_valid_r ? 3'(fin_task_r) : 3'd0;
        out_data_nxt.finish_turnover   = fin_valid_r ? 16'(fin_turn_r) : 16'd0;
        out_data_nxt.finish_run_time   = fin_valid_r ? 16'(fin_run_r) : 16'd0;
        out_data_nxt.finish_start_time = fin_valid_r ? 16'(fin_start_r) : 16'd0;
        state_nxt                      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cur_time_r   <= '0;
      run_active_r <= 1'b0;
      run_slot_r   <= '0;
      fin_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cur_time_r   <= cur_time_nxt;
      run_active_r <= run_active_nxt;
      run_slot_r   <= run_slot_nxt;
      fin_valid_r  <= fin_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    idx_r       <= idx_nxt;
    lim_r       <= lim_nxt;
    pick_pos_r  <= pick_pos_nxt;
    k_r         <= k_nxt;
    pick_task_r <= pick_task_nxt;
    rrec_r      <= rrec_nxt;
    have_best_r <= have_best_nxt;
    found_r     <= found_nxt;
    best_prio_r <= best_prio_nxt;
    fin_task_r  <= fin_task_nxt;
    fin_turn_r  <= fin_turn_nxt;
    fin_run_r   <= fin_run_nxt;
    fin_start_r <= fin_start_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPTS_ASSERT_IMP(a_out_idle, out_valid_r, state_r == S_IDLE, "result word outside idle")
  `PPTS_ASSERT(a_accept, (start && !busy) |=> state_r == S_DECODE, "accepted word not decoded")
  `PPTS_ASSERT_IMP(a_run_slot, run_active_r, int'(run_slot_r) < NUM_TASKS,
    "running slot out of range")
  `PPTS_ASSERT_IMP(a_task_count, state_r == S_IDLE,
    (CW+1)'(rq_count) + (CW+1)'(wq_count) + (CW+1)'(run_active_r) <= (CW+1)'(NUM_TASKS),
    "more queued tasks than slots")
endmodule
`default_nettype wire
